[rtl/prfp_pkg.sv]
// Package for the player reply frame parser.
// Holds frame byte constants and positions, reply codes and the event kind type.
// No dependencies.
`default_nettype none

package prfp_pkg;

    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] END_BYTE     = 8'hEF;

    localparam logic [7:0] CODE_IN      = 8'h3A;
    localparam logic [7:0] CODE_OUT     = 8'h3B;
    localparam logic [7:0] CODE_DONE    = 8'h3D;
    localparam logic [7:0] CODE_FILES   = 8'h48;
    localparam logic [7:0] CODE_FOLDERS = 8'h4F;

    localparam int unsigned POS_W = 4;

    localparam logic [POS_W-1:0] POS_CODE  = 4'd3;
    localparam logic [POS_W-1:0] POS_HIGH  = 4'd5;
    localparam logic [POS_W-1:0] POS_LOW   = 4'd6;
    localparam logic [POS_W-1:0] LAST_POS  = 4'd9;

    typedef enum logic [2:0] {
        KIND_CARD_IN   = 3'd0,
        KIND_CARD_OUT  = 3'd1,
        KIND_TRACK_END = 3'd2,
        KIND_FILES     = 3'd3,
        KIND_FOLDERS   = 3'd4
    } event_kind_t;

endpackage : prfp_pkg

`default_nettype wire

[rtl/prfp_in_if.sv]
// Input channel of the reply frame parser: one received UART byte per transaction.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface prfp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface : prfp_in_if

`default_nettype wire

[rtl/prfp_out_if.sv]
// Output channel of the reply frame parser: one decoded reply event per transaction.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface prfp_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [15:0] event_value;
    logic        card_present;
    logic        track_ended;

    modport source (output valid, output event_kind, output event_value,
                    output card_present, output track_ended, input ready);
    modport sink   (input valid, input event_kind, input event_value,
                    input card_present, input track_ended, output ready);

endinterface : prfp_out_if

`default_nettype wire

[rtl/player_reply_frame_parser_unit.sv]
// An accepted end byte goes through the input register, the parse step and the result register to the output.
// Throughput: one byte per cycle; the parse step sits between the input register and
// the result register, and stalls only while a result waits and the output is not ready.
// Reset (rst_n low, asynchronous): frame position 0, code and value bytes 0,
// card flag set, track-ended flag clear, both registers empty.
// Depends on prfp_pkg, prfp_in_if and prfp_out_if.
`default_nettype none

module player_reply_frame_parser_unit
    import prfp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    prfp_in_if.sink     rx,
    prfp_out_if.source  evt
);

    // input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    // parser state
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        hi_reg,   hi_next;
    logic [7:0]        lo_reg,   lo_next;
    logic              card_reg, card_next;
    logic              done_reg, done_next;

    // result register
    logic              out_valid_reg;
    event_kind_t       kind_reg;
    logic [15:0]       value_reg;
    logic              card_out_reg;
    logic              done_out_reg;

    logic              advance;
    logic              res_valid;
    event_kind_t       res_kind;
    logic [15:0]       res_value;

    // process the held byte when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || evt.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        pos_next  = pos_reg;
        code_next = code_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        card_next = card_reg;
        done_next = done_reg;
        res_valid = 1'b0;
        res_kind  = KIND_CARD_IN;
        res_value = '0;
        if (advance)
        begin
            if (pos_reg == '0)
            begin
                if (in_byte_reg == START_BYTE)
                    pos_next = 4'd1;
            end
            else if (pos_reg < LAST_POS)
            begin
                if (pos_reg == POS_CODE)
                    code_next = in_byte_reg;
                else if (pos_reg == POS_HIGH)
                    hi_next = in_byte_reg;
                else if (pos_reg == POS_LOW)
                    lo_next = in_byte_reg;
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                // end of frame: drop it unless the end byte matches and the code is known
                pos_next = '0;
                if (in_byte_reg == END_BYTE)
                begin
                    unique case (code_reg)
                        CODE_IN:
                        begin
                            card_next = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = KIND_CARD_IN;
                        end
                        CODE_OUT:
                        begin
                            card_next = 1'b0;
                            res_valid = 1'b1;
                            res_kind  = KIND_CARD_OUT;
                        end
                        CODE_DONE:
                        begin
                            done_next = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = KIND_TRACK_END;
                        end
                        CODE_FILES:
                        begin
                            res_valid = 1'b1;
                            res_kind  = KIND_FILES;
                            res_value = {hi_reg, lo_reg};
                        end
                        CODE_FOLDERS:
                        begin
                            res_valid = 1'b1;
                            res_kind  = KIND_FOLDERS;
                            res_value = {hi_reg, lo_reg};
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            code_reg      <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            card_reg      <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (advance || evt.ready)
                out_valid_reg <= res_valid;
            pos_reg  <= pos_next;
            code_reg <= code_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            card_reg <= card_next;
            done_reg <= done_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
        if (advance && res_valid)
        begin
            kind_reg     <= res_kind;
            value_reg    <= res_value;
            card_out_reg <= card_next;
            done_out_reg <= done_next;
        end
    end

    assign evt.valid        = out_valid_reg;
    assign evt.event_kind   = kind_reg;
    assign evt.event_value  = value_reg;
    assign evt.card_present = card_out_reg;
    assign evt.track_ended  = done_out_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position beyond end byte");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("track-ended flag cleared");

    a_result_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid) |=> (pos_reg == '0 && out_valid_reg))
        else $error("result without return to frame start");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_FILES && kind_reg != KIND_FOLDERS)
        |-> value_reg == '0)
        else $error("nonzero value on a flag event");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !evt.ready) |-> !advance)
        else $error("pending result overwritten");
`endif

endmodule : player_reply_frame_parser_unit

`default_nettype wire

[tb/player_reply_frame_parser_unit_tb.sv]
// Testbench for player_reply_frame_parser_unit: feeds reply frames, noise and broken frames
// at random pacing and checks every decoded event against an in-bench frame decoder.
// Depends on prfp_pkg, prfp_in_if, prfp_out_if and the parser RTL.
`timescale 1ns / 100ps

module player_reply_frame_parser_unit_tb;
    import prfp_pkg::*;

    localparam int unsigned  CLK_PERIOD     = 20;
    localparam int unsigned  STALL_LIMIT    = 4000;
    localparam int unsigned  HOLD_OFF       = 300;
    localparam logic [7:0]   CODE_STATUS    = 8'h42;
    localparam logic [7:0]   BAD_END        = 8'hEE;

    typedef struct {
        event_kind_t  kind;
        logic [15:0]  value;
        logic         card;
        logic         ended;
    } reply_event_t;

    // Frame decoder and the queue of events it has produced but not yet seen.
    class reply_scoreboard;
        logic [POS_W-1:0]  pos;
        logic [7:0]        code;
        logic [7:0]        hi;
        logic [7:0]        lo;
        logic              card;
        logic              finished;
        reply_event_t      pending_events[$];
        int                errors;
        int                predicted;

        function new();
            pos = '0;
            code = '0;
            hi = '0;
            lo = '0;
            card = 1'b1;
            finished = 1'b0;
            errors = 0;
            predicted = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            reply_event_t ev;
            if (pos == '0) begin
                if (b == START_BYTE)
                    pos = 4'd1;
                return;
            end
            if (pos < LAST_POS) begin
                case (pos)
                    POS_CODE: code = b;
                    POS_HIGH: hi = b;
                    POS_LOW:  lo = b;
                    default:  ;
                endcase
                pos = pos + 4'd1;
                return;
            end
            // end position: drop the frame unless the end byte matches and the code is known
            pos = '0;
            if (b != END_BYTE)
                return;
            ev.value = 16'h0000;
            case (code)
                CODE_IN:
                begin
                    card = 1'b1;
                    ev.kind = KIND_CARD_IN;
                end
                CODE_OUT:
                begin
                    card = 1'b0;
                    ev.kind = KIND_CARD_OUT;
                end
                CODE_DONE:
                begin
                    finished = 1'b1;
                    ev.kind = KIND_TRACK_END;
                end
                CODE_FILES:
                begin
                    ev.kind = KIND_FILES;
                    ev.value = {hi, lo};
                end
                CODE_FOLDERS:
                begin
                    ev.kind = KIND_FOLDERS;
                    ev.value = {hi, lo};
                end
                default:
                    return;
            endcase
            ev.card = card;
            ev.ended = finished;
            pending_events.push_back(ev);
            predicted++;
        endfunction

        function void check_event(logic [2:0] kind, logic [15:0] value, logic card_now,
                                  logic ended_now);
            reply_event_t want;
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d value %0d", kind, value);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (value !== want.value) begin
                $error("event_value: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (card_now !== want.card) begin
                $error("card_present: expected %0b, got %0b", want.card, card_now);
                errors++;
            end
            if (ended_now !== want.ended) begin
                $error("track_ended: expected %0b, got %0b", want.ended, ended_now);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    prfp_in_if  rx_if ();
    prfp_out_if evt_if ();

    player_reply_frame_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .evt   (evt_if)
    );

    reply_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int frame_bytes    = 0;
    int quiet_cycles   = 0;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        evt_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                evt_if.ready <= 1'b0;
            end
            else
                evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (evt_if.valid && evt_if.ready)
                sb.check_event(evt_if.event_kind, evt_if.event_value, evt_if.card_present,
                               evt_if.track_ended);
            if (rx_if.valid && rx_if.ready)
                sb.note_byte(rx_if.rx_byte);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (evt_if.valid && evt_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** player_reply_frame_parser_unit: FAILED **");
                $finish;
            end
        end
    end

    // Entered and left right after a rising edge; returns once the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
    endtask

    task automatic send_frame(input logic [7:0] code, input logic [15:0] value,
                              input logic [7:0] tail, input bit stuff_start);
        logic [7:0] fill [5];
        for (int i = 0; i < 5; i++)
            fill[i] = stuff_start ? START_BYTE : 8'($urandom);
        send_byte(START_BYTE);
        send_byte(fill[0]);
        send_byte(fill[1]);
        send_byte(code);
        send_byte(fill[2]);
        send_byte(value[15:8]);
        send_byte(value[7:0]);
        send_byte(fill[3]);
        send_byte(fill[4]);
        send_byte(tail);
        frame_bytes += 10;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int          target;
        logic [7:0]  code;
        logic [15:0] value;
        logic [7:0]  tail;
        target = frame_bytes + n_bytes;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (frame_bytes < target) begin
            if ($urandom_range(99) < 15) begin
                // line noise or a stray start byte that breaks the next frame
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom));
            end
            else begin
                if ($urandom_range(99) < 85) begin
                    case ($urandom_range(4))
                        0:       code = CODE_IN;
                        1:       code = CODE_OUT;
                        2:       code = CODE_DONE;
                        3:       code = CODE_FILES;
                        default: code = CODE_FOLDERS;
                    endcase
                end
                else
                    code = 8'($urandom);
                case ($urandom_range(9))
                    0:       value = 16'h0000;
                    1:       value = 16'hFFFF;
                    default: value = 16'($urandom);
                endcase
                tail = ($urandom_range(99) < 90) ? END_BYTE : 8'($urandom);
                send_frame(code, value, tail, $urandom_range(99) < 5);
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise before sync, every code, value extremes,
        // start byte as data, bad end byte, unknown code
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        send_frame(CODE_OUT, 16'h0000, END_BYTE, 1'b0);
        send_frame(CODE_DONE, 16'hFFFF, END_BYTE, 1'b0);
        send_frame(CODE_IN, 16'h1234, END_BYTE, 1'b0);
        send_frame(CODE_FILES, 16'hFFFF, END_BYTE, 1'b1);
        send_frame(CODE_FOLDERS, 16'h0000, END_BYTE, 1'b0);
        send_frame(CODE_FOLDERS, 16'h8001, BAD_END, 1'b0);
        send_frame(CODE_STATUS, 16'h5AA5, END_BYTE, 1'b0);
        send_frame(CODE_FILES, 16'h0100, END_BYTE, 1'b0);

        run_phase(0, 0, 90);
        run_phase(49, 0, 90);
        run_phase(0, 49, 90);
        run_phase(28, 28, 90);

        // hold the output off while frames keep coming, so the input backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = HOLD_OFF;
        repeat (6)
            send_frame(CODE_FILES, 16'($urandom), END_BYTE, 1'b0);

        rx_if.valid <= 1'b0;

        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("** player_reply_frame_parser_unit: PASSED **");
        else
            $display("** player_reply_frame_parser_unit: FAILED **");
        $finish;
    end

endmodule

[player_reply_frame_parser_unit.f]
rtl/prfp_pkg.sv
rtl/prfp_in_if.sv
rtl/prfp_out_if.sv
rtl/player_reply_frame_parser_unit.sv
tb/player_reply_frame_parser_unit_tb.sv
